[design/free_list_slot_allocator_top_defines.svh]
// assertion helpers shared by the checker
`ifndef FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// property checked on every rising edge, quiet while reset is asserted
`define FSA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define FSA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/fsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fsa_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int SLOT_FIELD_W   = 8;
	localparam int PROFILE_W      = 8;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_ALIVE = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} fsm_t;

	// strobes from the controller to the slot store
	typedef struct packed {
		logic rd_en;
		logic link_we;
		logic slot_we;
	} store_ctl_t;

endpackage
`default_nettype wire

[design/fsa_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface fsa_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          action;
	logic [fsa_pkg::PROFILE_W-1:0]       profile_index;
	logic [fsa_pkg::SLOT_FIELD_W-1:0]    slot_index;

	modport source (output valid, action, profile_index, slot_index, input ready);
	modport sink (input valid, action, profile_index, slot_index, output ready);
endinterface

interface fsa_res_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic [fsa_pkg::SLOT_FIELD_W-1:0]    slot_granted;
	logic [fsa_pkg::PROFILE_W-1:0]       profile_out;
	logic                                slot_alive;

	modport source (output valid, status, slot_granted, profile_out, slot_alive, input ready);
	modport sink (input valid, status, slot_granted, profile_out, slot_alive, output ready);
endinterface
`default_nettype wire

[design/fsa_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module fsa_store #(
	parameter int SLOT_COUNT = fsa_pkg::SLOT_COUNT_DEF
) (
	input  wire                           clk,
	input  fsa_pkg::store_ctl_t           ctl,
	input  wire  [$clog2(SLOT_COUNT)-1:0] link_raddr,
	input  wire  [$clog2(SLOT_COUNT)-1:0] slot_raddr,
	input  wire  [$clog2(SLOT_COUNT)-1:0] link_waddr,
	input  wire  [$clog2(SLOT_COUNT+1)-1:0] link_wdata,
	input  wire  [$clog2(SLOT_COUNT)-1:0] slot_waddr,
	input  wire  [fsa_pkg::PROFILE_W:0]   slot_wdata,
	output logic [$clog2(SLOT_COUNT+1)-1:0] link_rdata,
	output logic [fsa_pkg::PROFILE_W:0]   slot_rdata
);

	localparam int PTR_W = $clog2(SLOT_COUNT + 1);
	localparam int ENT_W = fsa_pkg::PROFILE_W + 1;

	// free-list successor of each slot
	logic [PTR_W-1:0] link_mem [SLOT_COUNT];
	// {alive, profile} of each slot
	logic [ENT_W-1:0] slot_mem [SLOT_COUNT];

	logic [PTR_W-1:0] link_rd_q;
	logic [ENT_W-1:0] slot_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (ctl.rd_en) begin
			link_rd_q <= link_mem[link_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (ctl.rd_en) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	assign link_rdata = link_rd_q;
	assign slot_rdata = slot_rd_q;

endmodule
`default_nettype wire

[design/fsa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module fsa_ctrl #(
	parameter int SLOT_COUNT = fsa_pkg::SLOT_COUNT_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	fsa_cmd_if.sink                         cmd,
	fsa_res_if.source                       res,
	output fsa_pkg::store_ctl_t             ctl,
	output logic [$clog2(SLOT_COUNT)-1:0]   link_raddr,
	output logic [$clog2(SLOT_COUNT)-1:0]   slot_raddr,
	output logic [$clog2(SLOT_COUNT)-1:0]   link_waddr,
	output logic [$clog2(SLOT_COUNT+1)-1:0] link_wdata,
	output logic [$clog2(SLOT_COUNT)-1:0]   slot_waddr,
	output logic [fsa_pkg::PROFILE_W:0]     slot_wdata,
	input  wire  [$clog2(SLOT_COUNT+1)-1:0] link_rdata,
	input  wire  [fsa_pkg::PROFILE_W:0]     slot_rdata
);

	localparam int PTR_W = $clog2(SLOT_COUNT + 1);
	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int PW    = fsa_pkg::PROFILE_W;
	localparam int SW    = fsa_pkg::SLOT_FIELD_W;
	localparam int CMP_W = (PTR_W > SW) ? PTR_W : SW;
	localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOT_COUNT);

	fsa_pkg::fsm_t    state_q, state_d;
	fsa_pkg::action_t action_q;
	logic [PW-1:0]    prof_q;
	logic [SW-1:0]    sidx_q;

	logic [PTR_W-1:0] free_head_q, free_head_d;
	logic [PTR_W-1:0] high_water_q, high_water_d;
	logic [PTR_W-1:0] live_count_q, live_count_d;

	logic             res_valid_q;
	fsa_pkg::status_t status_q, status_d;
	logic [SW-1:0]    granted_q, granted_d;
	logic [PW-1:0]    prof_out_q, prof_out_d;
	logic             alive_out_q, alive_out_d;

	logic accept;
	logic exec_done;
	logic link_we_d, slot_we_d;

	logic [CMP_W-1:0] sidx_w, head_w, hw_w, live_w;
	logic             slot_known;
	logic             alive_now;

	assign accept    = cmd.valid && cmd.ready;
	// result register free, or emptied at this very edge
	assign exec_done = (state_q == fsa_pkg::S_EXEC) && (!res_valid_q || res.ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsa_pkg::S_IDLE: begin
				if (accept) state_d = fsa_pkg::S_EXEC;
			end
			fsa_pkg::S_EXEC: begin
				if (exec_done) state_d = fsa_pkg::S_IDLE;
			end
			default: state_d = fsa_pkg::S_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		cmd.ready   = 1'b0;
		ctl.rd_en   = 1'b0;
		ctl.link_we = 1'b0;
		ctl.slot_we = 1'b0;
		unique case (state_q)
			fsa_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				ctl.rd_en = cmd.valid;
			end
			fsa_pkg::S_EXEC: begin
				ctl.link_we = exec_done && link_we_d;
				ctl.slot_we = exec_done && slot_we_d;
			end
			default: ;
		endcase
	end

	// reads go out with the transaction itself
	assign link_raddr = free_head_q[IDX_W-1:0];
	assign slot_raddr = IDX_W'(cmd.slot_index);

	assign sidx_w = CMP_W'(sidx_q);
	assign head_w = CMP_W'(free_head_q);
	assign hw_w   = CMP_W'(high_water_q);
	assign live_w = CMP_W'(live_count_q);

	// a slot from 1 up to below the mark has been written; slot 0 and slots at or beyond it read as not alive
	assign slot_known = (sidx_w != '0) && (sidx_w < hw_w);
	assign alive_now  = slot_known && slot_rdata[PW];

	always_comb begin
		status_d     = fsa_pkg::ST_OK;
		granted_d    = '0;
		prof_out_d   = '0;
		alive_out_d  = 1'b0;
		free_head_d  = free_head_q;
		high_water_d = high_water_q;
		live_count_d = live_count_q;
		link_we_d    = 1'b0;
		slot_we_d    = 1'b0;
		link_waddr   = free_head_q[IDX_W-1:0];
		link_wdata   = free_head_q;
		slot_waddr   = free_head_q[IDX_W-1:0];
		slot_wdata   = {1'b1, prof_q};
		unique case (action_q)
			fsa_pkg::ACT_ALLOC: begin
				if (live_w >= SLOTS_C || head_w >= SLOTS_C) begin
					status_d = fsa_pkg::ST_FULL;
				end else begin
					granted_d    = SW'(free_head_q);
					slot_we_d    = 1'b1;
					live_count_d = live_count_q + PTR_W'(1);
					if (free_head_q == high_water_q) begin
						high_water_d = high_water_q + PTR_W'(1);
						free_head_d  = free_head_q + PTR_W'(1);
					end else begin
						free_head_d = link_rdata;
					end
				end
			end
			fsa_pkg::ACT_FREE: begin
				if (sidx_w >= SLOTS_C) begin
					status_d = fsa_pkg::ST_INVALID;
				end else if (!alive_now) begin
					status_d = fsa_pkg::ST_NOT_ALIVE;
				end else begin
					// push onto the list, keep the last profile for queries
					slot_we_d    = 1'b1;
					slot_waddr   = IDX_W'(sidx_q);
					slot_wdata   = {1'b0, slot_rdata[PW-1:0]};
					link_we_d    = 1'b1;
					link_waddr   = IDX_W'(sidx_q);
					free_head_d  = PTR_W'(sidx_w);
					live_count_d = live_count_q - PTR_W'(1);
				end
			end
			fsa_pkg::ACT_QUERY: begin
				if (!slot_known) begin
					status_d = fsa_pkg::ST_INVALID;
				end else begin
					prof_out_d  = slot_rdata[PW-1:0];
					alive_out_d = slot_rdata[PW];
				end
			end
			default: status_d = fsa_pkg::ST_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fsa_pkg::S_IDLE;
			free_head_q  <= PTR_W'(1);
			high_water_q <= PTR_W'(1);
			live_count_q <= PTR_W'(1);
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_done) begin
				free_head_q  <= free_head_d;
				high_water_q <= high_water_d;
				live_count_q <= live_count_d;
			end
			if (exec_done) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= fsa_pkg::action_t'(cmd.action);
			prof_q   <= cmd.profile_index;
			sidx_q   <= cmd.slot_index;
		end
		if (exec_done) begin
			status_q    <= status_d;
			granted_q   <= granted_d;
			prof_out_q  <= prof_out_d;
			alive_out_q <= alive_out_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.slot_granted = granted_q;
	assign res.profile_out  = prof_out_q;
	assign res.slot_alive   = alive_out_q;

endmodule
`default_nettype wire

[design/free_list_slot_allocator_top.sv]
// free list slot allocator
//
// cmd channel: one transaction per operation (allocate, free or query a slot);
//   allocate records profile_index in the granted slot, free and query use
//   slot_index. slot 0 is the reserved stub and is never handed out.
// res channel: exactly one transaction per cmd transaction, in order, with
//   status, granted slot, stored profile and alive flag.
// result: the operation is accepted in idle, then its result is registered
//   in the execute state once the result register is free or emptied.
//   the next cmd is taken only once the last one leaves execute, as set by
//   the read-modify-write of the link and slot memories (read with the
//   transaction, write back in the execute cycle).
// only one operation is in flight, so a write back always lands before the
//   next read is issued and no forwarding is needed.
// stall: a waiting result does not block the next cmd transaction; that
//   operation then holds in its execute cycle until the result is taken.
// reset: free head, high-water mark and live count return to 1; memories are
//   not cleared, slots at or beyond the high-water mark read as not alive, so
//   the block is ready as soon as reset is released, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module free_list_slot_allocator_top #(
	parameter int SLOT_COUNT = fsa_pkg::SLOT_COUNT_DEF
) (
	input wire        clk,
	input wire        arst_n,
	fsa_cmd_if.sink   cmd,
	fsa_res_if.source res
);

	localparam int PTR_W = $clog2(SLOT_COUNT + 1);
	localparam int IDX_W = $clog2(SLOT_COUNT);

	fsa_pkg::store_ctl_t         ctl;
	logic [IDX_W-1:0]            link_raddr, slot_raddr, link_waddr, slot_waddr;
	logic [PTR_W-1:0]            link_wdata, link_rdata;
	logic [fsa_pkg::PROFILE_W:0] slot_wdata, slot_rdata;

	// sequencing, pointers, status decode and the result register
	fsa_ctrl #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.ctl       (ctl),
		.link_raddr(link_raddr),
		.slot_raddr(slot_raddr),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.slot_waddr(slot_waddr),
		.slot_wdata(slot_wdata),
		.link_rdata(link_rdata),
		.slot_rdata(slot_rdata)
	);

	// link memory and {alive, profile} memory, registered reads
	fsa_store #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_store (
		.clk       (clk),
		.ctl       (ctl),
		.link_raddr(link_raddr),
		.slot_raddr(slot_raddr),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.slot_waddr(slot_waddr),
		.slot_wdata(slot_wdata),
		.link_rdata(link_rdata),
		.slot_rdata(slot_rdata)
	);

endmodule
`default_nettype wire

[design/fsa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "free_list_slot_allocator_top_defines.svh"
module fsa_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       cmd_valid,
	input wire       cmd_ready,
	input wire       res_valid,
	input wire       res_ready,
	input wire [1:0] res_status
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && cmd_ready;

	// a stalled result holds
	`FSA_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res_status), "result dropped or changed while stalled")

	// one operation at a time
	`FSA_ASSERT(a_no_b2b, clk, arst_n, cmd_acc |=> !cmd_acc, "cmd transactions on consecutive cycles")

	// a result register free or emptied at acceptance lets the result through execute without a stall
	`FSA_ASSERT(a_latency, clk, arst_n, cmd_acc && (!res_valid || res_ready) |-> ##2 res_valid, "result late")

	// a fresh result always follows an accepted cmd transaction with only its execute state between
	`FSA_ASSERT(a_no_phantom, clk, arst_n, $rose(res_valid) |-> $past(cmd_acc, 2), "result without a cmd transaction")

endmodule

bind free_list_slot_allocator_top fsa_checker u_fsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_status(res.status)
);
`default_nettype wire

[test/free_list_slot_allocator_top_tb.sv]
`timescale 1ns / 1ps
module free_list_slot_allocator_top_tb;
	import fsa_pkg::*;

	localparam int SLOTS        = SLOT_COUNT_DEF;
	localparam int RANDOM_OPS   = 600;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 20;
	// action code the block does not define, answered with invalid index
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// one cmd transaction
	typedef struct packed {
		logic [1:0]              action;
		logic [PROFILE_W-1:0]    profile_index;
		logic [SLOT_FIELD_W-1:0] slot_index;
	} slot_op_t;

	// one res transaction
	typedef struct packed {
		status_t                 status;
		logic [SLOT_FIELD_W-1:0] slot_granted;
		logic [PROFILE_W-1:0]    profile_out;
		logic                    slot_alive;
	} slot_outcome_t;

	// shape of the random traffic: fill the pool, empty it, then mixed use
	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_CHURN
	} traffic_mode_e;

	logic clk;
	logic arst_n;

	fsa_cmd_if cmd_bus ();
	fsa_res_if res_bus ();

	free_list_slot_allocator_top #(
		.SLOT_COUNT(SLOTS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	// operations waiting to be sent; the head stays until its transaction is taken
	slot_op_t      pending_ops[$];
	// outcomes predicted for accepted operations, oldest first
	slot_outcome_t expected_outcomes[$];

	// allocator image kept by the testbench
	logic [8:0]           pool_link[0:SLOTS-1];
	bit                   pool_alive[0:SLOTS-1];
	logic [PROFILE_W-1:0] pool_profile[0:SLOTS-1];
	logic [8:0]           pool_head;
	logic [8:0]           pool_high_water;
	logic [8:0]           pool_live;

	// tallies for the closing summary
	int n_granted, n_full, n_freed, n_not_alive, n_query_ok, n_invalid;
	int checked_count;
	int mismatch_count;
	int cycle_count;

	// handshake bookkeeping for the driver
	bit cmd_busy;
	int burst_left;
	int gap_left;

	// receiver stall pattern, reloaded every so often
	logic [15:0] ready_pattern;
	int          pattern_age;

	// advance the allocator image by one operation and return its outcome
	function automatic slot_outcome_t allocator_outcome(input slot_op_t op);
		slot_outcome_t r;
		logic [8:0]    slot;
		r.status       = ST_OK;
		r.slot_granted = '0;
		r.profile_out  = '0;
		r.slot_alive   = 1'b0;
		case (op.action)
			ACT_ALLOC: begin
				slot = pool_head;
				if (pool_live >= SLOTS || slot >= SLOTS) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					// head at the mark: bump both, else pop the free list
					if (slot == pool_high_water) begin
						pool_high_water++;
						pool_head++;
					end else begin
						pool_head = pool_link[slot[7:0]];
					end
					pool_live++;
					pool_alive[slot[7:0]]   = 1'b1;
					pool_profile[slot[7:0]] = op.profile_index;
					r.slot_granted          = slot[7:0];
					n_granted++;
				end
			end
			ACT_FREE: begin
				if (!pool_alive[op.slot_index]) begin
					r.status = ST_NOT_ALIVE;
					n_not_alive++;
				end else begin
					pool_alive[op.slot_index] = 1'b0;
					pool_link[op.slot_index]  = pool_head;
					pool_head                 = {1'b0, op.slot_index};
					pool_live--;
					n_freed++;
				end
			end
			ACT_QUERY: begin
				if (op.slot_index == 0 || op.slot_index >= pool_high_water) begin
					r.status = ST_INVALID;
					n_invalid++;
				end else begin
					r.profile_out = pool_profile[op.slot_index];
					r.slot_alive  = pool_alive[op.slot_index];
					n_query_ok++;
				end
			end
			default: begin
				r.status = ST_INVALID;
				n_invalid++;
			end
		endcase
		return r;
	endfunction

	function automatic slot_op_t make_op(input logic [1:0] action,
		input logic [7:0] profile_index, input logic [7:0] slot_index);
		slot_op_t op;
		op.action        = action;
		op.profile_index = profile_index;
		op.slot_index    = slot_index;
		return op;
	endfunction

	// random live slot, or the stub when nothing is allocated
	function automatic logic [7:0] any_live_slot();
		int n;
		int k;
		n = 0;
		for (int i = 1; i < SLOTS; i++)
			if (pool_alive[i])
				n++;
		if (n == 0)
			return 8'd0;
		k = $urandom_range(n - 1);
		for (int i = 1; i < SLOTS; i++) begin
			if (pool_alive[i]) begin
				if (k == 0)
					return 8'(i);
				k--;
			end
		end
		return 8'd0;
	endfunction

	// random slot below the high-water mark, alive or freed; any slot while none is used
	function automatic logic [7:0] any_used_slot();
		if (pool_high_water > 1)
			return 8'($urandom_range(pool_high_water - 1, 1));
		return 8'($urandom_range(255));
	endfunction

	// mostly well-formed traffic of the given shape, a little noise on top
	function automatic slot_op_t random_op(input traffic_mode_e mode);
		int roll;
		int alloc_pct;
		int free_pct;
		logic [7:0] prof;
		prof = 8'($urandom);
		roll = $urandom_range(99);
		if (roll < 5)
			return make_op(2'($urandom_range(3)), prof, 8'($urandom));
		case (mode)
			MODE_FILL: begin
				alloc_pct = 90;
				free_pct  = 95;
			end
			MODE_DRAIN: begin
				alloc_pct = 8;
				free_pct  = 85;
			end
			default: begin
				alloc_pct = 40;
				free_pct  = 75;
			end
		endcase
		roll = $urandom_range(99);
		if (roll < alloc_pct)
			return make_op(ACT_ALLOC, prof, 8'($urandom));
		if (roll < free_pct)
			return make_op(ACT_FREE, prof, any_live_slot());
		return make_op(ACT_QUERY, prof, any_used_slot());
	endfunction

	task automatic compare_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("free_list_slot_allocator_top test failed");
			$finish;
		end
	end

	// cmd driver: bursts of back-to-back transactions with random gaps between;
	// valid holds with its payload until the transaction is taken
	always @(negedge clk) begin
		if (arst_n && !cmd_busy) begin
			if (gap_left != 0) begin
				gap_left--;
				cmd_bus.valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				cmd_bus.valid         <= 1'b1;
				cmd_bus.action        <= pending_ops[0].action;
				cmd_bus.profile_index <= pending_ops[0].profile_index;
				cmd_bus.slot_index    <= pending_ops[0].slot_index;
				cmd_busy = 1'b1;
				if (burst_left <= 1) begin
					// now and then a long stretch with no gaps at all
					burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 16);
					gap_left = $urandom_range(0, 7);
				end else begin
					burst_left--;
				end
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// res receiver: ready follows a rotating pattern that is swapped now and then
	always @(negedge clk) begin
		if (pattern_age <= 0) begin
			case ($urandom_range(3))
				0:       ready_pattern = 16'hFFFF;
				1:       ready_pattern = 16'($urandom);
				2:       ready_pattern = 16'(1 << $urandom_range(15));
				default: ready_pattern = 16'($urandom) | 16'($urandom);
			endcase
			if (ready_pattern == 16'd0)
				ready_pattern = 16'h0001;
			pattern_age = $urandom_range(40, 200);
		end
		pattern_age--;
		res_bus.ready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
	end

	// monitor: predict on every accepted cmd transaction, check every res one
	always @(posedge clk) begin
		slot_op_t      op;
		slot_outcome_t want;
		if (arst_n) begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				op = make_op(cmd_bus.action, cmd_bus.profile_index, cmd_bus.slot_index);
				expected_outcomes.push_back(allocator_outcome(op));
				void'(pending_ops.pop_front());
				cmd_busy = 1'b0;
			end
			if (res_bus.valid && res_bus.ready) begin
				if (expected_outcomes.size() == 0) begin
					$error("res transaction with nothing outstanding: status %0d slot %0d",
						res_bus.status, res_bus.slot_granted);
					mismatch_count++;
				end else begin
					want = expected_outcomes.pop_front();
					compare_field("status", 8'(want.status), 8'(res_bus.status));
					compare_field("slot_granted", want.slot_granted, res_bus.slot_granted);
					compare_field("profile_out", want.profile_out, res_bus.profile_out);
					compare_field("slot_alive", 8'(want.slot_alive), 8'(res_bus.slot_alive));
					checked_count++;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		traffic_mode_e mode;
		int            random_sent;
		int            chunk;

		arst_n                = 1'b0;
		cmd_bus.valid         = 1'b0;
		cmd_bus.action        = ACT_ALLOC;
		cmd_bus.profile_index = '0;
		cmd_bus.slot_index    = '0;
		res_bus.ready         = 1'b0;
		cmd_busy              = 1'b0;
		burst_left            = 0;
		gap_left              = 0;
		pattern_age           = 0;
		ready_pattern         = 16'hFFFF;
		cycle_count           = 0;
		mismatch_count        = 0;
		checked_count         = 0;
		for (int i = 0; i < SLOTS; i++) begin
			pool_alive[i]   = 1'b0;
			pool_link[i]    = '0;
			pool_profile[i] = '0;
		end
		pool_head       = 9'd1;
		pool_high_water = 9'd1;
		pool_live       = 9'd1;

		// the stub and untouched slots right after reset, and the unused action
		pending_ops.push_back(make_op(ACT_QUERY, 8'hFF, 8'd0));
		pending_ops.push_back(make_op(ACT_QUERY, 8'h00, 8'hFF));
		pending_ops.push_back(make_op(ACT_FREE, 8'hFF, 8'd0));
		pending_ops.push_back(make_op(ACT_FREE, 8'h00, 8'hFF));
		pending_ops.push_back(make_op(ACT_UNUSED, 8'hFF, 8'hFF));
		// grants that bump the high-water mark, extreme profiles
		pending_ops.push_back(make_op(ACT_ALLOC, 8'h00, 8'h00));
		pending_ops.push_back(make_op(ACT_ALLOC, 8'hFF, 8'hFF));
		pending_ops.push_back(make_op(ACT_ALLOC, 8'hA5, 8'h5A));
		pending_ops.push_back(make_op(ACT_QUERY, 8'h00, 8'd1));
		pending_ops.push_back(make_op(ACT_QUERY, 8'h00, 8'd2));
		pending_ops.push_back(make_op(ACT_QUERY, 8'h00, 8'd3));
		// query right at the mark
		pending_ops.push_back(make_op(ACT_QUERY, 8'h00, 8'd4));
		// free, double free, query of a freed slot keeps its last profile
		pending_ops.push_back(make_op(ACT_FREE, 8'h00, 8'd2));
		pending_ops.push_back(make_op(ACT_FREE, 8'h00, 8'd2));
		pending_ops.push_back(make_op(ACT_QUERY, 8'h00, 8'd2));
		// reuse through the link, then a bump again
		pending_ops.push_back(make_op(ACT_ALLOC, 8'h5A, 8'h00));
		pending_ops.push_back(make_op(ACT_ALLOC, 8'h3C, 8'h00));
		// free list is last in, first out
		pending_ops.push_back(make_op(ACT_FREE, 8'h00, 8'd1));
		pending_ops.push_back(make_op(ACT_FREE, 8'h00, 8'd3));
		pending_ops.push_back(make_op(ACT_ALLOC, 8'h11, 8'h00));
		pending_ops.push_back(make_op(ACT_ALLOC, 8'h22, 8'h00));
		pending_ops.push_back(make_op(ACT_QUERY, 8'h00, 8'd1));
		pending_ops.push_back(make_op(ACT_UNUSED, 8'h00, 8'h00));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// random part in chunks, each drawn from the image once it is current:
		// fill the pool until it refuses, empty most of it, then mixed traffic
		mode        = MODE_FILL;
		random_sent = 0;
		while (random_sent < RANDOM_OPS) begin
			while (pending_ops.size() != 0)
				@(posedge clk);
			if (mode == MODE_FILL && pool_live == SLOTS && n_full >= 8)
				mode = MODE_DRAIN;
			else if (mode == MODE_DRAIN && pool_live <= 40)
				mode = MODE_CHURN;
			chunk = $urandom_range(1, 24);
			repeat (chunk) begin
				pending_ops.push_back(random_op(mode));
				random_sent++;
			end
		end

		while (pending_ops.size() != 0 || expected_outcomes.size() != 0)
			@(posedge clk);
		// catch any stray res transaction after the last one
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d transactions: %0d grants, %0d pool-full refusals, %0d frees",
			checked_count, n_granted, n_full, n_freed);
		$display("%0d rejected frees, %0d queries answered, %0d invalid replies, mark at %0d",
			n_not_alive, n_query_ok, n_invalid, pool_high_water);
		if (mismatch_count == 0) begin
			$display("free_list_slot_allocator_top test passed");
		end else begin
			$display("free_list_slot_allocator_top test failed");
		end
		$finish;
	end

endmodule

[free_list_slot_allocator_top.f]
+incdir+design
design/fsa_pkg.sv
design/fsa_if.sv
design/fsa_store.sv
design/fsa_ctrl.sv
design/free_list_slot_allocator_top.sv
design/fsa_checker.sv
test/free_list_slot_allocator_top_tb.sv
